### sv/igf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igf_pkg: shared types and constants for the five-point image gradient
// Register codes, input function codes, tap selects, the per-item control
// record handed from the position control to the gradient datapath.
// ----------------------------------------------------------------------------
package igf_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int PIXEL_BITS_DEFAULT = 16;
    localparam int GRAD_EXTRA_BITS    = 5;
    localparam int HEIGHT_LIMIT       = 1024;
    localparam int H_BITS             = $clog2(HEIGHT_LIMIT + 1);
    localparam int Y_BITS             = $clog2(HEIGHT_LIMIT);
    localparam int MIN_SIZE           = 3;
    localparam int CFG_BITS           = 11;
    localparam int CFG_INDEX_BITS     = 1;
    localparam int NUM_LINES          = 4;
    localparam int SLOT_BITS          = $clog2(NUM_LINES);
    localparam int TAP_COUNT          = 5;

    localparam logic [CFG_BITS-1:0] CFG_SIZE_RESET = CFG_BITS'(1024);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic {
        FUNC_PIXEL = 1'b0,
        FUNC_DRAIN = 1'b1
    } func_t;

    // Source of one kernel tap, relative to the center position
    typedef enum logic [2:0] {
        TAP_M2 = 3'd0,
        TAP_M1 = 3'd1,
        TAP_C  = 3'd2,
        TAP_P1 = 3'd3,
        TAP_P2 = 3'd4
    } tap_t;

    // Per-item control record
    typedef struct packed {
        logic                 emit;
        logic                 rd;
        logic [SLOT_BITS-1:0] rslot;
        logic [SLOT_BITS-1:0] yslot;
        logic                 x_first;
        logic                 x_second;
        logic                 x_pen;
        logic                 x_last;
        logic                 y_first;
        logic                 y_second;
        logic                 y_pen;
        logic                 y_last;
        logic                 last;
    } ctl_t;

    // Mirror the tap at offset -2 (no edge repeat)
    function automatic tap_t tap_m2(input logic first, input logic second);
        return first ? TAP_P2 : (second ? TAP_C : TAP_M2);
    endfunction

    // Mirror the tap at offset -1
    function automatic tap_t tap_m1(input logic first);
        return first ? TAP_P1 : TAP_M1;
    endfunction

    // Mirror the tap at offset +1
    function automatic tap_t tap_p1(input logic last);
        return last ? TAP_M1 : TAP_P1;
    endfunction

    // Mirror the tap at offset +2
    function automatic tap_t tap_p2(input logic last, input logic pen);
        return last ? TAP_M2 : (pen ? TAP_C : TAP_P2);
    endfunction

endpackage

### sv/igf_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igf_line_store: one row of pixel storage
// Simple dual-port memory, one write and one registered read per cycle.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module igf_line_store
    import igf_pkg::*;
#(
    parameter int DEPTH     = MAX_WIDTH_DEFAULT,
    parameter int DATA_BITS = PIXEL_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic signed [DATA_BITS-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic signed [DATA_BITS-1:0] rd_data
);

    logic signed [DATA_BITS-1:0] store_mem [DEPTH];
    logic signed [DATA_BITS-1:0] rd_data_reg;

    // Write the new sample, read the old one
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/igf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igf_ctrl: configuration and frame position control
// Holds the size registers, the input, output and read-ahead positions, and
// decides per item whether it writes a pixel, reads ahead and gives a result.
// ----------------------------------------------------------------------------
module igf_ctrl
    import igf_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [CFG_BITS-1:0]          cfg_data,
    // input item
    input  logic                         in_valid,
    input  logic                         func,
    input  logic                         adv,
    output logic                         accept,
    // row memories
    output logic                         wr_en,
    output logic [SLOT_BITS-1:0]         wr_slot,
    output logic [$clog2(MAX_WIDTH)-1:0] wr_col,
    output logic                         rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0] rd_col,
    // to the datapath
    output ctl_t                         ctl
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int W_BITS   = $clog2(MAX_WIDTH + 1);

    logic [CFG_BITS-1:0]  frame_width_reg;
    logic [CFG_BITS-1:0]  frame_height_reg;
    logic [W_BITS-1:0]    w_reg, w_next;
    logic [H_BITS-1:0]    h_reg, h_next;
    logic [COL_BITS-1:0]  in_col_reg, in_col_next;
    logic [H_BITS-1:0]    in_row_reg, in_row_next;
    logic [COL_BITS-1:0]  out_col_reg, out_col_next;
    logic [Y_BITS-1:0]    out_row_reg, out_row_next;
    logic [COL_BITS-1:0]  rd_col_reg, rd_col_next;
    logic [SLOT_BITS-1:0] rd_slot_reg, rd_slot_next;

    logic [31:0]       fw_ext, fh_ext;
    logic [W_BITS-1:0] w_cfg, w_use;
    logic [H_BITS-1:0] h_cfg, h_use;
    logic              idle, have, is_drain, wr, emit, rd, last;
    logic              in_col_end, out_col_end, rd_col_end, prefetch;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CFG_SIZE_RESET;
            frame_height_reg <= CFG_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
            endcase
        end
    end

    // Clamp the frame size: width to what the line stores hold, height to HEIGHT_LIMIT, both to at least MIN_SIZE
    always_comb
    begin
        fw_ext = 32'(frame_width_reg);
        fh_ext = 32'(frame_height_reg);
        if (fw_ext < 32'(MIN_SIZE))
            w_cfg = W_BITS'(MIN_SIZE);
        else if (fw_ext > 32'(MAX_WIDTH))
            w_cfg = W_BITS'(MAX_WIDTH);
        else
            w_cfg = W_BITS'(fw_ext);
        if (fh_ext < 32'(MIN_SIZE))
            h_cfg = H_BITS'(MIN_SIZE);
        else if (fh_ext > 32'(HEIGHT_LIMIT))
            h_cfg = H_BITS'(HEIGHT_LIMIT);
        else
            h_cfg = H_BITS'(fh_ext);
    end

    // Decode what the item does
    always_comb
    begin
        idle     = (in_col_reg == '0) && (in_row_reg == '0)
                   && (out_col_reg == '0) && (out_row_reg == '0);
        w_use    = idle ? w_cfg : w_reg;
        h_use    = idle ? h_cfg : h_reg;
        is_drain = (func_t'(func) == FUNC_DRAIN);
        have     = in_row_reg < h_use;
        wr       = have && !is_drain;
        emit     = have ? (wr && (in_row_reg >= H_BITS'(2))) : 1'b1;

        in_col_end  = W_BITS'(in_col_reg) == w_use - W_BITS'(1);
        out_col_end = W_BITS'(out_col_reg) == w_use - W_BITS'(1);
        rd_col_end  = W_BITS'(rd_col_reg) == w_use - W_BITS'(1);

        // read ahead the first two pixels of row 0 at the end of row 1
        prefetch = wr && (in_row_reg == H_BITS'(1))
                   && (W_BITS'(in_col_reg) >= w_use - W_BITS'(2));
        rd       = emit || prefetch;
        last     = emit && out_col_end
                   && (H_BITS'(out_row_reg) == h_use - H_BITS'(1));
    end

    // Advance the positions
    always_comb
    begin
        w_next       = w_reg;
        h_next       = h_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        rd_col_next  = rd_col_reg;
        rd_slot_next = rd_slot_reg;
        if (accept)
        begin
            if (idle && !is_drain)
            begin
                w_next = w_cfg;
                h_next = h_cfg;
            end
            if (wr)
            begin
                in_col_next = in_col_end ? '0 : in_col_reg + COL_BITS'(1);
                in_row_next = in_col_end ? in_row_reg + H_BITS'(1) : in_row_reg;
            end
            if (emit)
            begin
                out_col_next = out_col_end ? '0 : out_col_reg + COL_BITS'(1);
                out_row_next = out_col_end ? out_row_reg + Y_BITS'(1) : out_row_reg;
            end
            if (rd)
            begin
                rd_col_next  = rd_col_end ? '0 : rd_col_reg + COL_BITS'(1);
                rd_slot_next = rd_col_end ? rd_slot_reg + SLOT_BITS'(1) : rd_slot_reg;
            end
            if (last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                rd_col_next  = '0;
                rd_slot_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg       <= W_BITS'(MAX_WIDTH);
            h_reg       <= H_BITS'(HEIGHT_LIMIT);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            rd_col_reg  <= '0;
            rd_slot_reg <= '0;
        end
        else
        begin
            w_reg       <= w_next;
            h_reg       <= h_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            rd_col_reg  <= rd_col_next;
            rd_slot_reg <= rd_slot_next;
        end
    end

    // Memory controls and per-item record
    assign accept  = in_valid && adv;
    assign wr_en   = accept && wr;
    assign wr_slot = in_row_reg[SLOT_BITS-1:0];
    assign wr_col  = in_col_reg;
    assign rd_en   = accept && rd;
    assign rd_col  = rd_col_reg;

    always_comb
    begin
        ctl.emit     = emit;
        ctl.rd       = rd;
        ctl.rslot    = rd_slot_reg;
        ctl.yslot    = out_row_reg[SLOT_BITS-1:0];
        ctl.x_first  = (out_col_reg == '0);
        ctl.x_second = (out_col_reg == COL_BITS'(1));
        ctl.x_pen    = W_BITS'(out_col_reg) == w_use - W_BITS'(2);
        ctl.x_last   = out_col_end;
        ctl.y_first  = (out_row_reg == '0);
        ctl.y_second = (out_row_reg == Y_BITS'(1));
        ctl.y_pen    = H_BITS'(out_row_reg) == h_use - H_BITS'(2);
        ctl.y_last   = H_BITS'(out_row_reg) == h_use - H_BITS'(1);
        ctl.last     = last;
    end

endmodule

### sv/igf_grad.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igf_grad: tap windows, kernel sums and result register
// Keeps the last read-ahead samples of the center row and the last two read
// columns, mirrors taps at the frame edges and forms the (1,-8,8,-1) sums.
// ----------------------------------------------------------------------------
module igf_grad
    import igf_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         accept,
    input  ctl_t                                         ctl,
    input  logic signed [PIXEL_BITS-1:0]                 pixel,
    input  logic signed [PIXEL_BITS-1:0]                 rd_q [NUM_LINES],
    input  logic                                         out_stall,
    output logic                                         adv,
    output logic                                         out_valid,
    output logic signed [PIXEL_BITS+GRAD_EXTRA_BITS-1:0] grad_x,
    output logic signed [PIXEL_BITS+GRAD_EXTRA_BITS-1:0] grad_y,
    output logic                                         last_of_frame
);

    localparam int GRAD_BITS = PIXEL_BITS + GRAD_EXTRA_BITS;

    logic                         s1_valid_reg;
    ctl_t                         s1_ctl_reg;
    logic signed [PIXEL_BITS-1:0] s1_pix_reg;
    logic signed [PIXEL_BITS-1:0] col_reg [2][NUM_LINES];
    logic signed [PIXEL_BITS-1:0] center_reg [4];
    logic                         out_valid_reg;
    logic signed [GRAD_BITS-1:0]  grad_x_reg, grad_y_reg;
    logic                         last_reg;

    logic signed [PIXEL_BITS-1:0] fresh;
    logic signed [PIXEL_BITS-1:0] xwin [TAP_COUNT];
    logic signed [PIXEL_BITS-1:0] ywin [TAP_COUNT];
    logic signed [PIXEL_BITS-1:0] vx_m2, vx_m1, vx_p1, vx_p2;
    logic signed [PIXEL_BITS-1:0] vy_m2, vy_m1, vy_p1, vy_p2;
    logic signed [GRAD_BITS-1:0]  ex_m2, ex_m1, ex_p1, ex_p2;
    logic signed [GRAD_BITS-1:0]  ey_m2, ey_m1, ey_p1, ey_p2;
    logic signed [GRAD_BITS-1:0]  gx, gy;
    logic [SLOT_BITS-1:0]         slot_m2, slot_m1, slot_p1;
    logic                         shift;

    // Move the pipe whenever the result register is free or being taken
    assign adv   = !out_valid_reg || !out_stall;
    assign shift = adv && s1_valid_reg && s1_ctl_reg.rd;

    // Hold the accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && accept)
        begin
            s1_ctl_reg <= ctl;
            s1_pix_reg <= pixel;
        end
    end

    // Advance the windows by one read-ahead column
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            for (int i = 0; i < NUM_LINES; i++)
            begin
                col_reg[0][i] <= rd_q[i];
                col_reg[1][i] <= col_reg[0][i];
            end
            center_reg[0] <= fresh;
            center_reg[1] <= center_reg[0];
            center_reg[2] <= center_reg[1];
            center_reg[3] <= center_reg[2];
        end
    end

    // Select the mirrored taps and form the sums
    always_comb
    begin
        fresh   = rd_q[s1_ctl_reg.rslot];
        slot_m2 = s1_ctl_reg.yslot - SLOT_BITS'(2);
        slot_m1 = s1_ctl_reg.yslot - SLOT_BITS'(1);
        slot_p1 = s1_ctl_reg.yslot + SLOT_BITS'(1);

        xwin[TAP_M2] = center_reg[3];
        xwin[TAP_M1] = center_reg[2];
        xwin[TAP_C]  = center_reg[1];
        xwin[TAP_P1] = center_reg[0];
        xwin[TAP_P2] = fresh;

        ywin[TAP_M2] = col_reg[1][slot_m2];
        ywin[TAP_M1] = col_reg[1][slot_m1];
        ywin[TAP_C]  = col_reg[1][s1_ctl_reg.yslot];
        ywin[TAP_P1] = col_reg[1][slot_p1];
        ywin[TAP_P2] = s1_pix_reg;

        vx_m2 = xwin[tap_m2(s1_ctl_reg.x_first, s1_ctl_reg.x_second)];
        vx_m1 = xwin[tap_m1(s1_ctl_reg.x_first)];
        vx_p1 = xwin[tap_p1(s1_ctl_reg.x_last)];
        vx_p2 = xwin[tap_p2(s1_ctl_reg.x_last, s1_ctl_reg.x_pen)];
        vy_m2 = ywin[tap_m2(s1_ctl_reg.y_first, s1_ctl_reg.y_second)];
        vy_m1 = ywin[tap_m1(s1_ctl_reg.y_first)];
        vy_p1 = ywin[tap_p1(s1_ctl_reg.y_last)];
        vy_p2 = ywin[tap_p2(s1_ctl_reg.y_last, s1_ctl_reg.y_pen)];

        ex_m2 = {{GRAD_EXTRA_BITS{vx_m2[PIXEL_BITS-1]}}, vx_m2};
        ex_m1 = {{GRAD_EXTRA_BITS{vx_m1[PIXEL_BITS-1]}}, vx_m1};
        ex_p1 = {{GRAD_EXTRA_BITS{vx_p1[PIXEL_BITS-1]}}, vx_p1};
        ex_p2 = {{GRAD_EXTRA_BITS{vx_p2[PIXEL_BITS-1]}}, vx_p2};
        ey_m2 = {{GRAD_EXTRA_BITS{vy_m2[PIXEL_BITS-1]}}, vy_m2};
        ey_m1 = {{GRAD_EXTRA_BITS{vy_m1[PIXEL_BITS-1]}}, vy_m1};
        ey_p1 = {{GRAD_EXTRA_BITS{vy_p1[PIXEL_BITS-1]}}, vy_p1};
        ey_p2 = {{GRAD_EXTRA_BITS{vy_p2[PIXEL_BITS-1]}}, vy_p2};

        gx = ex_m2 - (ex_m1 <<< 3) + (ex_p1 <<< 3) - ex_p2;
        gy = ey_m2 - (ey_m1 <<< 3) + (ey_p1 <<< 3) - ey_p2;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg && s1_ctl_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg && s1_ctl_reg.emit)
        begin
            grad_x_reg <= gx;
            grad_y_reg <= gy;
            last_reg   <= s1_ctl_reg.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign grad_x        = grad_x_reg;
    assign grad_y        = grad_y_reg;
    assign last_of_frame = last_reg;

endmodule

### sv/image_gradient_five_point.sv
`timescale 1ns / 1ps
// Results come from the result register, behind the held-item register; the
// result for pixel k is released by pixel k + 2*width, or by a drain tick once
// the frame is in. Throughput: one item per cycle unless out_stall is high, set
// by the single read port per row memory and the read-ahead of two columns.
// Reset clears positions and valids and loads 1024 into both size registers;
// the row memories are not cleared, every entry is written before it is read.
// ----------------------------------------------------------------------------
// image_gradient_five_point: streaming five-point image gradient
// Four row memories hold the recent rows; taps are mirrored at the frame
// edges and weighted (1,-8,8,-1), giving twelve times the gradient.
// ----------------------------------------------------------------------------
module image_gradient_five_point
    import igf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
    parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    // configuration
    input  logic                                         cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]                    cfg_index,
    input  logic [CFG_BITS-1:0]                          cfg_data,
    // input channel
    input  logic                                         in_valid,
    output logic                                         in_stall,
    input  logic                                         func,
    input  logic signed [PIXEL_BITS-1:0]                 pixel_value,
    // output channel
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output logic signed [PIXEL_BITS+GRAD_EXTRA_BITS-1:0] grad_x,
    output logic signed [PIXEL_BITS+GRAD_EXTRA_BITS-1:0] grad_y,
    output logic                                         last_of_frame
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);

    logic                         adv;
    logic                         accept;
    logic                         wr_en;
    logic [SLOT_BITS-1:0]         wr_slot;
    logic [COL_BITS-1:0]          wr_col;
    logic                         rd_en;
    logic [COL_BITS-1:0]          rd_col;
    ctl_t                         ctl;
    logic signed [PIXEL_BITS-1:0] rd_q [NUM_LINES];

    // Position control and configuration
    igf_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .func      (func),
        .adv       (adv),
        .accept    (accept),
        .wr_en     (wr_en),
        .wr_slot   (wr_slot),
        .wr_col    (wr_col),
        .rd_en     (rd_en),
        .rd_col    (rd_col),
        .ctl       (ctl)
    );

    // One memory per stored row, all read at the same column
    for (genvar i = 0; i < NUM_LINES; i++)
    begin : g_line
        igf_line_store #(
            .DEPTH     (MAX_WIDTH),
            .DATA_BITS (PIXEL_BITS)
        ) u_line (
            .clk     (clk),
            .wr_en   (wr_en && (wr_slot == SLOT_BITS'(i))),
            .wr_addr (wr_col),
            .wr_data (pixel_value),
            .rd_en   (rd_en),
            .rd_addr (rd_col),
            .rd_data (rd_q[i])
        );
    end

    // Tap windows, sums and result register
    igf_grad #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_grad (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .ctl           (ctl),
        .pixel         (pixel_value),
        .rd_q          (rd_q),
        .out_stall     (out_stall),
        .adv           (adv),
        .out_valid     (out_valid),
        .grad_x        (grad_x),
        .grad_y        (grad_y),
        .last_of_frame (last_of_frame)
    );

    assign in_stall = !adv;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the streaming five-point image gradient
// Feeds frames of several sizes, including clamped ones, with drain ticks
// and noise. Each result is compared field by field with a local
// line-buffer model of the kernel, in order.
// ----------------------------------------------------------------------------
module tb_top;
    import igf_pkg::*;

    localparam int MAX_W = MAX_WIDTH_DEFAULT;
    localparam int PIX_W = PIXEL_BITS_DEFAULT;
    localparam int GRAD_W = PIXEL_BITS_DEFAULT + GRAD_EXTRA_BITS;
    localparam int DIR_ROWS = 18;
    localparam int RANDOM_PIXELS = 520;
    localparam int HOLD_PERIOD = 1000;
    localparam int HOLD_CYCLES = 150;
    localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;
    localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7fff;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     last;
    } grad_t;

    // How a stimulus row is checked
    typedef enum logic [1:0] {
        CHK_NONE,
        CHK_VALUE,
        CHK_MODEL
    } chk_t;

    typedef enum logic [2:0] {
        PAT_NOISE,
        PAT_EXTREME,
        PAT_SMALL,
        PAT_XSTEP,
        PAT_YSTEP
    } pattern_t;

    typedef enum logic [1:0] {
        SINK_FREE,
        SINK_LIGHT,
        SINK_HEAVY
    } sink_mode_t;

    typedef struct packed {
        func_t                   f;
        logic signed [PIX_W-1:0] pix;
        chk_t                    chk;
        grad_t                   res;
    } dir_row_t;

    localparam grad_t FLAT      = '{gx: '0, gy: '0, last: 1'b0};
    localparam grad_t FLAT_LAST = '{gx: '0, gy: '0, last: 1'b1};

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_BITS-1:0]      cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     func = FUNC_PIXEL;
    logic signed [PIX_W-1:0]  pixel_value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic                     last_of_frame;

    // Gradient model state
    logic [CFG_BITS-1:0]      reg_width;
    logic [CFG_BITS-1:0]      reg_height;
    int                       fr_w;
    int                       fr_h;
    int                       pos_in_col;
    int                       pos_in_row;
    int                       pos_out_col;
    int                       pos_out_row;
    logic signed [PIX_W-1:0]  line_mem [4*MAX_W];
    bit                       frame_done;

    grad_t                    pending_grads [$];
    dir_row_t                 dir_tab [DIR_ROWS];
    int                       mismatch_count = 0;
    int                       burst_left = 0;

    image_gradient_five_point uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .pixel_value   (pixel_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .grad_x        (grad_x),
        .grad_y        (grad_y),
        .last_of_frame (last_of_frame)
    );

    always #1 clk = ~clk;

    function automatic int clamp_size(input int v, input int hi);
        return (v < MIN_SIZE) ? MIN_SIZE : ((v > hi) ? hi : v);
    endfunction

    // Reflect a coordinate at the frame edge, edge pixel not repeated
    function automatic int mirror_coord(input int c, input int lim);
        if (c < 0)
            return -c;
        if (c > lim)
            return 2 * lim - c;
        return c;
    endfunction

    // Pixel at raster index j; the newest one may be the item in hand
    function automatic int fetch_pixel(input int j, input int n, input bit have,
                                       input logic signed [PIX_W-1:0] cur);
        if (have && j == n)
            return int'(cur);
        return int'(line_mem[j % (4 * fr_w)]);
    endfunction

    // Advance the model by one item; returns 1 when a result is released
    function automatic bit predict_gradient(input func_t f,
                                            input logic signed [PIX_W-1:0] pix,
                                            output grad_t res);
        int     n;
        int     x;
        int     y;
        int     t;
        int     ofs;
        int     wt;
        int     cx;
        int     cy;
        bit     have;
        bit     emit;
        longint sx;
        longint sy;
        res = '0;
        n = 0;
        // Latch the frame size on the first pixel of a frame
        if (pos_in_row == 0 && pos_in_col == 0 && pos_out_row == 0 && pos_out_col == 0) begin
            if (f == FUNC_DRAIN)
                return 1'b0;
            fr_w = clamp_size(int'(reg_width), MAX_W);
            fr_h = clamp_size(int'(reg_height), HEIGHT_LIMIT);
        end
        have = pos_in_row < fr_h;
        if (have && f == FUNC_DRAIN)
            return 1'b0;
        if (have)
            n = pos_in_row * fr_w + pos_in_col;
        emit = !have || pos_in_row >= 2;

        if (emit) begin
            x = pos_out_col;
            y = pos_out_row;
            sx = 0;
            sy = 0;
            for (t = 0; t < 4; t++) begin
                ofs = (t < 2) ? t - 2 : t - 1;
                case (t)
                    0: wt = 1;
                    1: wt = -8;
                    2: wt = 8;
                    default: wt = -1;
                endcase
                cx = mirror_coord(x + ofs, fr_w - 1);
                cy = mirror_coord(y + ofs, fr_h - 1);
                sx += wt * fetch_pixel(y * fr_w + cx, n, have, pix);
                sy += wt * fetch_pixel(cy * fr_w + x, n, have, pix);
            end
            res.gx = sx[GRAD_W-1:0];
            res.gy = sy[GRAD_W-1:0];
            res.last = (y * fr_w + x == fr_w * fr_h - 1);
        end

        if (have) begin
            line_mem[n % (4 * fr_w)] = pix;
            pos_in_col++;
            if (pos_in_col >= fr_w) begin
                pos_in_col = 0;
                pos_in_row++;
            end
        end

        if (emit) begin
            pos_out_col++;
            if (pos_out_col >= fr_w) begin
                pos_out_col = 0;
                pos_out_row++;
            end
            if (res.last) begin
                pos_in_col = 0;
                pos_in_row = 0;
                pos_out_col = 0;
                pos_out_row = 0;
                frame_done = 1'b1;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Offer one item in bursts with random gaps, then record what it releases
    task automatic send_item(input func_t f, input logic signed [PIX_W-1:0] pix,
                             input chk_t chk, input grad_t given_res);
        int    gap;
        bit    got;
        grad_t res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 30);
        end
        in_valid <= 1'b1;
        func <= f;
        pixel_value <= pix;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        got = predict_gradient(f, pix, res);
        case (chk)
            CHK_MODEL: if (got) pending_grads.push_back(res);
            CHK_VALUE: pending_grads.push_back(given_res);
            default: ;
        endcase
    endtask

    // Drop valid and wait until every expected result is out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_grads.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_frame_size(input int w, input int h);
        cfg_write <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data <= CFG_BITS'(w);
        @(posedge clk);
        reg_width = CFG_BITS'(w);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data <= CFG_BITS'(h);
        @(posedge clk);
        reg_height = CFG_BITS'(h);
        cfg_write <= 1'b0;
    endtask

    // One frame with a random pattern, noise ticks, then drain to its last result
    task automatic run_frame(input int fw, input int fh);
        pattern_t                pat;
        int                      i;
        logic signed [PIX_W-1:0] v;
        pat = pattern_t'($urandom_range(0, 4));
        frame_done = 1'b0;
        for (i = 0; i < fw * fh; i++) begin
            if ($urandom_range(0, 11) == 0)
                send_item(FUNC_DRAIN, PIX_W'($urandom), CHK_MODEL, FLAT);
            case (pat)
                PAT_EXTREME: v = $urandom_range(0, 1) ? PIX_MAX : PIX_MIN;
                PAT_SMALL:   v = PIX_W'(int'($urandom_range(0, 16)) - 8);
                PAT_XSTEP:   v = ((i % fw) >= fw / 2) ? PIX_MAX : PIX_MIN;
                PAT_YSTEP:   v = ((i / fw) >= fh / 2) ? PIX_MAX : PIX_MIN;
                default:     v = PIX_W'($urandom_range(0, 65535));
            endcase
            send_item(FUNC_PIXEL, v, CHK_MODEL, FLAT);
        end
        // A pixel sent while draining is lost, the block takes it as a tick
        while (!frame_done) begin
            if ($urandom_range(0, 9) == 0)
                send_item(FUNC_PIXEL, PIX_W'($urandom), CHK_MODEL, FLAT);
            else
                send_item(FUNC_DRAIN, PIX_W'($urandom), CHK_MODEL, FLAT);
        end
        if ($urandom_range(0, 5) == 0)
            send_item(FUNC_DRAIN, PIX_W'($urandom), CHK_MODEL, FLAT);
    endtask

    // Result sink: stall pattern, periodic long hold, in-order check
    initial begin : result_sink
        int         cyc;
        int         seg_left;
        sink_mode_t seg_mode;
        logic       stall_next;
        grad_t      e;
        cyc = 0;
        seg_left = 0;
        seg_mode = SINK_FREE;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                if (pending_grads.size() == 0) begin
                    $display("%0t ns: result with nothing expected: grad_x %0d grad_y %0d last %0b",
                             $time, grad_x, grad_y, last_of_frame);
                    mismatch_count++;
                end else begin
                    e = pending_grads.pop_front();
                    if (grad_x !== e.gx) begin
                        $display("%0t ns: grad_x expected %0d, got %0d", $time, e.gx, grad_x);
                        mismatch_count++;
                    end
                    if (grad_y !== e.gy) begin
                        $display("%0t ns: grad_y expected %0d, got %0d", $time, e.gy, grad_y);
                        mismatch_count++;
                    end
                    if (last_of_frame !== e.last) begin
                        $display("%0t ns: last_of_frame expected %0b, got %0b",
                                 $time, e.last, last_of_frame);
                        mismatch_count++;
                    end
                end
            end
            cyc++;
            if (seg_left == 0) begin
                seg_mode = sink_mode_t'($urandom_range(0, 2));
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            case (seg_mode)
                SINK_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
                SINK_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
                default:    stall_next = 1'b0;
            endcase
            // Hold off for a long stretch so the block backs up into its input
            if ((cyc % HOLD_PERIOD) >= HOLD_PERIOD - HOLD_CYCLES)
                stall_next = 1'b1;
            out_stall <= stall_next;
        end
    end

    // Stimulus
    initial begin : stimulus
        int i;
        int wv;
        int hv;
        int nfr;
        int random_pixels;
        reg_width = CFG_SIZE_RESET;
        reg_height = CFG_SIZE_RESET;
        fr_w = 1024;
        fr_h = 1024;
        pos_in_col = 0;
        pos_in_row = 0;
        pos_out_col = 0;
        pos_out_row = 0;
        frame_done = 1'b0;
        random_pixels = 0;

        // 3x3 frame of the most negative pixel: every gradient is zero.
        // Covers a tick before the frame, a tick mid-frame, a lost pixel
        // while draining and a tick after the frame has ended.
        dir_tab = '{
            '{FUNC_DRAIN, PIX_MAX, CHK_NONE,  FLAT},
            '{FUNC_PIXEL, PIX_MIN, CHK_NONE,  FLAT},
            '{FUNC_PIXEL, PIX_MIN, CHK_NONE,  FLAT},
            '{FUNC_PIXEL, PIX_MIN, CHK_NONE,  FLAT},
            '{FUNC_DRAIN, PIX_MAX, CHK_NONE,  FLAT},
            '{FUNC_PIXEL, PIX_MIN, CHK_NONE,  FLAT},
            '{FUNC_PIXEL, PIX_MIN, CHK_NONE,  FLAT},
            '{FUNC_PIXEL, PIX_MIN, CHK_NONE,  FLAT},
            '{FUNC_PIXEL, PIX_MIN, CHK_VALUE, FLAT},
            '{FUNC_PIXEL, PIX_MIN, CHK_VALUE, FLAT},
            '{FUNC_PIXEL, PIX_MIN, CHK_VALUE, FLAT},
            '{FUNC_DRAIN, PIX_MIN, CHK_VALUE, FLAT},
            '{FUNC_PIXEL, PIX_MAX, CHK_VALUE, FLAT},
            '{FUNC_DRAIN, PIX_MIN, CHK_VALUE, FLAT},
            '{FUNC_DRAIN, PIX_MIN, CHK_VALUE, FLAT},
            '{FUNC_DRAIN, PIX_MIN, CHK_VALUE, FLAT},
            '{FUNC_DRAIN, PIX_MIN, CHK_VALUE, FLAT_LAST},
            '{FUNC_DRAIN, PIX_MAX, CHK_NONE,  FLAT}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_frame_size(3, 3);
        foreach (dir_tab[i])
            send_item(dir_tab[i].f, dir_tab[i].pix, dir_tab[i].chk, dir_tab[i].res);
        wait_idle();

        // Register extremes: zero and tiny sizes clamp to three
        set_frame_size(0, 0);
        run_frame(3, 3);
        wait_idle();
        set_frame_size(1, 2);
        run_frame(3, 3);
        run_frame(3, 3);
        wait_idle();

        // Random small frames, sizes changed between phases
        while (random_pixels < RANDOM_PIXELS) begin
            wv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            hv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            set_frame_size(wv, hv);
            nfr = $urandom_range(1, 3);
            for (i = 0; i < nfr; i++) begin
                run_frame(clamp_size(wv, MAX_W), clamp_size(hv, HEIGHT_LIMIT));
                random_pixels += clamp_size(wv, MAX_W) * clamp_size(hv, HEIGHT_LIMIT);
            end
            wait_idle();
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Run limit
    initial begin : watchdog
        #1000000;
        $display("tb: failure");
        $finish;
    end

endmodule

### files.f
sv/igf_pkg.sv
sv/igf_line_store.sv
sv/igf_ctrl.sv
sv/igf_grad.sv
sv/image_gradient_five_point.sv
sim/tb_top.sv
